[sv/nos_pkg.sv]
// ----------------------------------------------------------------------------
// nos_pkg
// Types and constants shared by the note-off scheduler modules.
// ----------------------------------------------------------------------------
package nos_pkg;

  localparam logic [3:0] NOTE_ON_NIBBLE  = 4'h9;
  localparam logic [3:0] NOTE_OFF_NIBBLE = 4'h8;
  localparam logic [7:0] OFF_VELOCITY    = 8'd127;

  typedef struct packed {
    logic [31:0] off_time;
    logic [3:0]  chan;
    logic [7:0]  note;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_EVT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic pop;
    logic insert;
    logic emit_evt;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic head_due;
    logic note_on;
    logic eot;
    logic cnt_zero;
    logic cnt_one;
    logic n_lt_depth;
    logic slot_free;
  } sts_t;

endpackage

[sv/note_off_scheduler_top.sv]
// ----------------------------------------------------------------------------
// note_off_scheduler_top
// Emits due note-offs, passes each event, queues note-ons' note-offs, flushes at tlast.
// ----------------------------------------------------------------------------
// After the accept, the first result beat is registered from the pop state when
// a note-off is due, otherwise from the event state after any insertion; further
// beats follow while out_tready is high, and insertion shares the cycle that ends
// pops. The sequencer accepts a new event only in the idle state, after the last
// result beat of the previous one is in the single output register.
// Reset clears the sequencer, the pending count and the output valid only.
module note_off_scheduler_top
  import nos_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // event_time[31:0], event_status[39:32], event_data1[47:40],
  // event_data2[55:48], note_duration[87:56]
  input  logic [87:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_time[31:0], out_status[39:32], out_data1[47:40], out_data2[55:48]
  output logic [55:0] out_tdata,
  // generated[0], queue_overflow[1]
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  cmd_t cmd;
  sts_t sts;

  nos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nos_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[sv/nos_queue.sv]
// ----------------------------------------------------------------------------
// nos_queue
// Sorted row of note-off cells with parallel insertion and head removal.
// ----------------------------------------------------------------------------
module nos_queue
  import nos_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   pop,
  input  logic   insert,
  input  entry_t ins_entry,
  output entry_t head,
  output logic   empty,
  output logic   one,
  output logic   full
);

  entry_t               cell_r   [QUEUE_DEPTH];
  entry_t               cell_nxt [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] gt;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;

  assign empty = (count_r == '0);
  assign one   = (count_r == CW'(1));
  assign full  = (count_r == CW'(QUEUE_DEPTH));
  assign head  = cell_r[0];

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic shift_in;
    logic take_new;

    assign gt[g] = (CW'(g) < count_r) && (cell_r[g].off_time > ins_entry.off_time);

    if (g > 0) begin : g_sh
      assign shift_in = gt[g-1];
    end else begin : g_nosh
      assign shift_in = 1'b0;
    end

    assign take_new = gt[g] || (CW'(g) == count_r);

    if (g < QUEUE_DEPTH - 1) begin : g_mid
      always_comb begin
        cell_nxt[g] = cell_r[g];
        if (pop) begin
          cell_nxt[g] = cell_r[g+1];
        end else if (insert && !full) begin
          if (shift_in) begin
            cell_nxt[g] = cell_r[(g > 0) ? g - 1 : 0];
          end else if (take_new) begin
            cell_nxt[g] = ins_entry;
          end
        end
      end
    end else begin : g_end
      always_comb begin
        cell_nxt[g] = cell_r[g];
        if (!pop && insert && !full) begin
          if (shift_in) begin
            cell_nxt[g] = cell_r[(g > 0) ? g - 1 : 0];
          end else if (take_new) begin
            cell_nxt[g] = ins_entry;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      cell_r[g] <= cell_nxt[g];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (pop && !empty) begin
      count_nxt = count_r - CW'(1);
    end else if (insert && !full) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

[sv/nos_dp.sv]
// ----------------------------------------------------------------------------
// nos_dp
// Datapath: input holding registers, note-off time, queue, result count and
// the output register.
// ----------------------------------------------------------------------------
module nos_dp
  import nos_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [87:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  localparam int NW = $clog2(QUEUE_DEPTH + 2);

  logic [31:0]   evt_time_r;
  logic [7:0]    evt_status_r;
  logic [7:0]    evt_data1_r;
  logic [7:0]    evt_data2_r;
  logic          eot_r;
  logic [31:0]   off_time_r;
  logic          ovf_r;
  logic [NW-1:0] n_r;
  logic [32:0]   off_sum;

  logic          out_valid_r;
  logic [31:0]   out_time_r;
  logic [7:0]    out_status_r;
  logic [7:0]    out_data1_r;
  logic [7:0]    out_data2_r;
  logic          out_gen_r;
  logic          out_ovf_r;
  logic          out_last_r;

  entry_t        ins_entry;
  entry_t        head;
  logic          q_empty;
  logic          q_one;
  logic          q_full;

  assign off_sum = {1'b0, in_tdata[31:0]} + {1'b0, in_tdata[87:56]};

  assign ins_entry.off_time = off_time_r;
  assign ins_entry.chan     = evt_status_r[3:0];
  assign ins_entry.note     = evt_data1_r;

  nos_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (cmd.pop),
    .insert    (cmd.insert),
    .ins_entry (ins_entry),
    .head      (head),
    .empty     (q_empty),
    .one       (q_one),
    .full      (q_full)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      evt_time_r   <= in_tdata[31:0];
      evt_status_r <= in_tdata[39:32];
      evt_data1_r  <= in_tdata[47:40];
      evt_data2_r  <= in_tdata[55:48];
      eot_r        <= in_tlast;
      off_time_r   <= off_sum[32] ? 32'hFFFF_FFFF : off_sum[31:0];
      ovf_r        <= 1'b0;
      n_r          <= '0;
    end else begin
      if (cmd.insert && q_full) begin
        ovf_r <= 1'b1;
      end
      if (cmd.pop || cmd.emit_evt) begin
        n_r <= n_r + NW'(1);
      end
    end
  end

  assign sts.head_due   = !q_empty && (head.off_time <= evt_time_r);
  assign sts.note_on    = (evt_status_r[7:4] == NOTE_ON_NIBBLE);
  assign sts.eot        = eot_r;
  assign sts.cnt_zero   = q_empty;
  assign sts.cnt_one    = q_one;
  assign sts.n_lt_depth = (n_r < NW'(QUEUE_DEPTH));
  assign sts.slot_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.pop || cmd.emit_evt) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_time_r   <= head.off_time;
      out_status_r <= {NOTE_OFF_NIBBLE, head.chan};
      out_data1_r  <= head.note;
      out_data2_r  <= OFF_VELOCITY;
      out_gen_r    <= 1'b1;
      out_ovf_r    <= 1'b0;
      out_last_r   <= cmd.last;
    end else if (cmd.emit_evt) begin
      out_time_r   <= evt_time_r;
      out_status_r <= evt_status_r;
      out_data1_r  <= evt_data1_r;
      out_data2_r  <= evt_data2_r;
      out_gen_r    <= 1'b0;
      out_ovf_r    <= ovf_r;
      out_last_r   <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data2_r, out_data1_r, out_status_r, out_time_r};
  assign out_tuser  = {out_ovf_r, out_gen_r};
  assign out_tlast  = out_last_r;

endmodule

[sv/nos_ctrl.sv]
// ----------------------------------------------------------------------------
// nos_ctrl
// Sequencer for one event: due note-offs, insertion, the event, the flush.
// ----------------------------------------------------------------------------
module nos_ctrl
  import nos_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   evt_last;
  logic   flush_last;

  assign evt_last   = !(sts.eot && !sts.cnt_zero && sts.n_lt_depth);
  assign flush_last = sts.cnt_one || !sts.n_lt_depth;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (!(sts.head_due && sts.n_lt_depth)) begin
          state_nxt = ST_EVT;
        end
      end
      ST_EVT: begin
        if (sts.slot_free) begin
          state_nxt = evt_last ? ST_IDLE : ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (sts.slot_free && flush_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_POP: begin
        if (sts.head_due && sts.n_lt_depth) begin
          cmd.pop = sts.slot_free;
        end else begin
          cmd.insert = sts.note_on;
        end
      end
      ST_EVT: begin
        cmd.emit_evt = sts.slot_free;
        cmd.last     = evt_last;
      end
      ST_FLUSH: begin
        cmd.pop  = sts.slot_free;
        cmd.last = flush_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/nos_checker.sv]
// ----------------------------------------------------------------------------
// nos_checker
// Port-level checks of the note-off scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module nos_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result beat keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // Only one event is worked on at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again while an event is in progress");

  // An overflow is reported on the passed event, never on a note-off.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1])
    else $error("overflow flagged on a generated note-off");

  // Reset leaves no result beat pending.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid after reset");

endmodule

bind note_off_scheduler_top nos_checker u_nos_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
